// ----- src/spq_pkg.sv -----
package spq_pkg;

  localparam int DEPTH = 8;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_DELETE = 1'b1
  } req_t;

  typedef struct packed {
    logic                    req_type;
    logic signed [VAL_W-1:0] value;
  } spq_in_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [3:0]              fill_level;
    logic signed [VAL_W-1:0] top_value;
  } spq_out_t;

  // command broadcast to every cell
  typedef struct packed {
    logic                    ins;
    logic                    del;
    logic signed [VAL_W-1:0] value;
  } spq_cmd_t;

endpackage

// ----- src/spq_cell.sv -----
module spq_cell (
  input  logic                            clk,
  input  spq_pkg::spq_cmd_t               cmd,
  input  logic                            occ,
  input  logic                            ge_prev,
  input  logic signed [spq_pkg::VAL_W-1:0] left_val,
  input  logic signed [spq_pkg::VAL_W-1:0] right_val,
  output logic                            ge,
  output logic                            eq,
  output logic signed [spq_pkg::VAL_W-1:0] val,
  output logic signed [spq_pkg::VAL_W-1:0] val_next
);

  logic signed [spq_pkg::VAL_W-1:0] val_r;
  logic signed [spq_pkg::VAL_W-1:0] val_nxt;

  // thermometer over the descending row: empty slots count as ge
  assign ge = !occ || (cmd.value >= val_r);
  assign eq = occ && (cmd.value == val_r);

  always_comb begin
    val_nxt = val_r;
    if (cmd.ins && ge) begin
      val_nxt = ge_prev ? left_val : cmd.value;
    end else if (cmd.del && ge) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val      = val_r;
  assign val_next = val_nxt;

endmodule

// ----- src/sorted_array_priority_queue_core.sv -----
// the result strobe is registered and rises in the cycle after the request is taken
// throughput: one request per cycle, every cell compares and shifts in parallel
// busy is never raised; the receiver cannot stall, so results never back up
// reset (rst_n low, synchronous) empties the queue and clears the strobe
// entry contents are not cleared; slots past the fill count are never shown
module sorted_array_priority_queue_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  spq_pkg::spq_in_t  in_item,
  output logic              out_valid,
  output spq_pkg::spq_out_t out_item
);

  localparam int D = spq_pkg::DEPTH;
  localparam int CW = spq_pkg::CNT_W;

  logic [CW-1:0]                   count_r, count_nxt;
  logic                            out_valid_r;
  spq_pkg::spq_out_t               out_item_r, out_item_nxt;
  logic                            accept;
  logic                            full, found;
  logic [D-1:0]                    occ, ge, eq;
  logic signed [spq_pkg::VAL_W-1:0] val [D];
  logic signed [spq_pkg::VAL_W-1:0] val_next [D];
  spq_pkg::spq_cmd_t               cmd;
  spq_pkg::status_t                status;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_r == CW'(D));
  assign found  = |eq;

  always_comb begin
    for (int k = 0; k < D; k++) begin
      occ[k] = (CW'(k) < count_r);
    end
  end

  always_comb begin
    cmd.value = in_item.value;
    cmd.ins   = 1'b0;
    cmd.del   = 1'b0;
    count_nxt = count_r;
    if (in_item.req_type == spq_pkg::REQ_INSERT) begin
      if (full) begin
        status = spq_pkg::ST_OVERFLOW;
      end else begin
        status    = spq_pkg::ST_OK;
        cmd.ins   = accept;
        count_nxt = count_r + CW'(1);
      end
    end else begin
      if (count_r == '0) begin
        status = spq_pkg::ST_EMPTY;
      end else if (!found) begin
        status = spq_pkg::ST_NOT_FOUND;
      end else begin
        status    = spq_pkg::ST_OK;
        cmd.del   = accept;
        count_nxt = count_r - CW'(1);
      end
    end
  end

  for (genvar k = 0; k < D; k++) begin : g_cell
    logic                            ge_prev;
    logic signed [spq_pkg::VAL_W-1:0] left_val, right_val;

    if (k == 0) begin : g_head
      assign ge_prev  = 1'b0;
      assign left_val = cmd.value;
    end else begin : g_body
      assign ge_prev  = ge[k-1];
      assign left_val = val[k-1];
    end

    if (k == D - 1) begin : g_tail
      assign right_val = val[k];
    end else begin : g_mid
      assign right_val = val[k+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .occ       (occ[k]),
      .ge_prev   (ge_prev),
      .left_val  (left_val),
      .right_val (right_val),
      .ge        (ge[k]),
      .eq        (eq[k]),
      .val       (val[k]),
      .val_next  (val_next[k])
    );
  end

  always_comb begin
    out_item_nxt.status     = status;
    out_item_nxt.fill_level = 4'(count_nxt);
    out_item_nxt.top_value  = (count_nxt != '0) ? val_next[0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
    if (accept) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ----- src/spq_checker.sv -----
module spq_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input spq_pkg::spq_in_t  in_item,
  input logic              out_valid,
  input spq_pkg::spq_out_t out_item
);

  // every taken transaction gets its strobe in the next cycle
  a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("missing result strobe");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy))
    else $error("result strobe without a request");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.fill_level <= 4'(spq_pkg::DEPTH)))
    else $error("fill level beyond depth");

  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.fill_level == 4'd0) |-> (out_item.top_value == '0))
    else $error("top value not zero on empty queue");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == spq_pkg::ST_EMPTY) |->
      (out_item.fill_level == 4'd0))
    else $error("empty status with entries stored");

endmodule

bind sorted_array_priority_queue_core spq_checker u_spq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);

// ----- verif/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_COUNT  = 1500;
  localparam int STALL_LIMIT = 1000;
  localparam logic signed [spq_pkg::VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [spq_pkg::VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

  typedef struct {
    spq_pkg::spq_in_t  req;
    bit                typed;
    spq_pkg::spq_out_t want;
  } step_row_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic              busy;
  spq_pkg::spq_in_t  in_item;
  logic              out_valid;
  spq_pkg::spq_out_t out_item;

  sorted_array_priority_queue_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always #1 clk = ~clk;

  // shadow copy of the sorted store, largest first
  logic signed [spq_pkg::VAL_W-1:0] shadow_entries [spq_pkg::DEPTH];
  int unsigned                      shadow_fill;
  spq_pkg::spq_out_t                pending_results [$];
  step_row_t                        directed_rows [$];
  int unsigned                      mismatch_count;
  int unsigned                      idle_cycles;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ns: mismatch on %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
    mismatch_count++;
  endtask

  function automatic spq_pkg::spq_out_t predict_queue_op(spq_pkg::spq_in_t req);
    logic signed [spq_pkg::VAL_W-1:0] v;
    int unsigned                      pos;
    int unsigned                      k;
    bit                               hit;
    spq_pkg::spq_out_t                res;
    v   = req.value;
    hit = 1'b0;
    pos = shadow_fill;
    if (req.req_type == spq_pkg::REQ_INSERT) begin
      if (shadow_fill >= spq_pkg::DEPTH) begin
        res.status = spq_pkg::ST_OVERFLOW;
      end else begin
        // equal values go ahead of existing ones
        for (k = 0; k < shadow_fill; k++) begin
          if (!hit && v >= shadow_entries[k]) begin
            pos = k;
            hit = 1'b1;
          end
        end
        for (k = shadow_fill; k > pos; k--)
          shadow_entries[k] = shadow_entries[k-1];
        shadow_entries[pos] = v;
        shadow_fill++;
        res.status = spq_pkg::ST_OK;
      end
    end else begin
      if (shadow_fill == 0) begin
        res.status = spq_pkg::ST_EMPTY;
      end else begin
        for (k = 0; k < shadow_fill; k++) begin
          if (!hit && shadow_entries[k] == v) begin
            pos = k;
            hit = 1'b1;
          end
        end
        if (!hit) begin
          res.status = spq_pkg::ST_NOT_FOUND;
        end else begin
          for (k = pos; k + 1 < shadow_fill; k++)
            shadow_entries[k] = shadow_entries[k+1];
          shadow_fill--;
          res.status = spq_pkg::ST_OK;
        end
      end
    end
    res.fill_level = shadow_fill[3:0];
    res.top_value  = (shadow_fill > 0) ? shadow_entries[0] : '0;
    return res;
  endfunction

  function automatic step_row_t mk_row(spq_pkg::req_t kind,
                                       logic signed [spq_pkg::VAL_W-1:0] v, bit typed,
                                       spq_pkg::status_t st, int unsigned fill,
                                       logic signed [spq_pkg::VAL_W-1:0] top);
    step_row_t r;
    r.req.req_type  = kind;
    r.req.value     = v;
    r.typed         = typed;
    r.want.status   = st;
    r.want.fill_level = fill[3:0];
    r.want.top_value  = top;
    return r;
  endfunction

  // drive one transaction and hold it until taken; start stays high afterwards
  task automatic send_request(spq_pkg::spq_in_t req, bit typed, spq_pkg::spq_out_t want);
    spq_pkg::spq_out_t predicted;
    @(negedge clk);
    start   <= 1'b1;
    in_item <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = predict_queue_op(req);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic idle_gap(int unsigned cycles);
    spq_pkg::spq_in_t noise;
    repeat (cycles) begin
      noise.req_type = $urandom_range(0, 1);
      noise.value    = $urandom;
      @(negedge clk);
      start   <= 1'b0;
      in_item <= noise;
    end
  endtask

  function automatic logic signed [spq_pkg::VAL_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5)
      return $signed($urandom_range(0, 6)) - 3;
    else if (r == 5)
      return $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
    else
      return $urandom;
  endfunction

  // result checker
  always @(posedge clk) begin
    spq_pkg::spq_out_t exp_res;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", {30'b0, out_item.status}, 32'b0);
      end else begin
        exp_res = pending_results.pop_front();
        if (out_item.status !== exp_res.status)
          report_mismatch("status", {30'b0, out_item.status}, {30'b0, exp_res.status});
        if (out_item.fill_level !== exp_res.fill_level)
          report_mismatch("fill_level", {28'b0, out_item.fill_level},
                          {28'b0, exp_res.fill_level});
        if (out_item.top_value !== exp_res.top_value)
          report_mismatch("top_value", out_item.top_value, exp_res.top_value);
      end
    end
  end

  // watchdog: no transaction on either side for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    spq_pkg::spq_in_t  req;
    spq_pkg::spq_out_t none;
    int unsigned       burst_left;
    int unsigned       ins_pct;
    int unsigned       n;
    none           = '0;
    mismatch_count = 0;
    idle_cycles    = 0;
    shadow_fill    = 0;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_item        = '0;

    directed_rows.push_back(mk_row(spq_pkg::REQ_DELETE, 0, 1, spq_pkg::ST_EMPTY, 0, 0));
    directed_rows.push_back(mk_row(spq_pkg::REQ_INSERT, VAL_MIN, 1, spq_pkg::ST_OK, 1, VAL_MIN));
    directed_rows.push_back(mk_row(spq_pkg::REQ_INSERT, VAL_MAX, 1, spq_pkg::ST_OK, 2, VAL_MAX));
    directed_rows.push_back(mk_row(spq_pkg::REQ_DELETE, 1, 1, spq_pkg::ST_NOT_FOUND, 2, VAL_MAX));
    directed_rows.push_back(mk_row(spq_pkg::REQ_INSERT, 0, 0, spq_pkg::ST_OK, 0, 0));
    directed_rows.push_back(mk_row(spq_pkg::REQ_INSERT, 0, 0, spq_pkg::ST_OK, 0, 0));
    directed_rows.push_back(mk_row(spq_pkg::REQ_INSERT, -1, 0, spq_pkg::ST_OK, 0, 0));
    directed_rows.push_back(mk_row(spq_pkg::REQ_INSERT, VAL_MAX, 0, spq_pkg::ST_OK, 0, 0));
    directed_rows.push_back(mk_row(spq_pkg::REQ_INSERT, VAL_MIN, 0, spq_pkg::ST_OK, 0, 0));
    directed_rows.push_back(mk_row(spq_pkg::REQ_INSERT, 1, 0, spq_pkg::ST_OK, 0, 0));
    directed_rows.push_back(mk_row(spq_pkg::REQ_INSERT, 5, 1, spq_pkg::ST_OVERFLOW, 8, VAL_MAX));
    directed_rows.push_back(mk_row(spq_pkg::REQ_DELETE, VAL_MAX, 0, spq_pkg::ST_OK, 0, 0));
    directed_rows.push_back(mk_row(spq_pkg::REQ_DELETE, VAL_MIN, 0, spq_pkg::ST_OK, 0, 0));
    directed_rows.push_back(mk_row(spq_pkg::REQ_DELETE, 0, 0, spq_pkg::ST_OK, 0, 0));
    directed_rows.push_back(mk_row(spq_pkg::REQ_DELETE, 12345, 1, spq_pkg::ST_NOT_FOUND, 5,
                                   VAL_MAX));
    directed_rows.push_back(mk_row(spq_pkg::REQ_DELETE, VAL_MAX, 0, spq_pkg::ST_OK, 0, 0));
    directed_rows.push_back(mk_row(spq_pkg::REQ_DELETE, 1, 0, spq_pkg::ST_OK, 0, 0));
    directed_rows.push_back(mk_row(spq_pkg::REQ_DELETE, 0, 0, spq_pkg::ST_OK, 0, 0));
    directed_rows.push_back(mk_row(spq_pkg::REQ_DELETE, -1, 0, spq_pkg::ST_OK, 0, 0));
    directed_rows.push_back(mk_row(spq_pkg::REQ_DELETE, VAL_MIN, 0, spq_pkg::ST_OK, 0, 0));
    directed_rows.push_back(mk_row(spq_pkg::REQ_DELETE, VAL_MIN, 1, spq_pkg::ST_EMPTY, 0, 0));
    directed_rows.push_back(mk_row(spq_pkg::REQ_INSERT, 32'sh5555_5555, 0, spq_pkg::ST_OK, 0, 0));
    directed_rows.push_back(mk_row(spq_pkg::REQ_INSERT, 32'shaaaa_aaaa, 0, spq_pkg::ST_OK, 0, 0));
    directed_rows.push_back(mk_row(spq_pkg::REQ_DELETE, 32'sh5555_5555, 0, spq_pkg::ST_OK, 0, 0));
    directed_rows.push_back(mk_row(spq_pkg::REQ_DELETE, 32'shaaaa_aaaa, 0, spq_pkg::ST_OK, 0, 0));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
      if ($urandom_range(0, 3) == 0)
        idle_gap($urandom_range(1, 3));
    end

    burst_left = 0;
    ins_pct    = 50;
    for (n = 0; n < ITEM_COUNT; n++) begin
      // drift the insert/delete mix so the store sits empty, half full and full
      if (n % 64 == 0)
        ins_pct = 25 * $urandom_range(1, 3);
      if ($urandom_range(1, 100) <= ins_pct) begin
        req.req_type = spq_pkg::REQ_INSERT;
        req.value    = pick_value();
      end else begin
        req.req_type = spq_pkg::REQ_DELETE;
        if (shadow_fill > 0 && $urandom_range(0, 9) < 6)
          req.value = shadow_entries[$urandom_range(0, shadow_fill - 1)];
        else
          req.value = pick_value();
      end
      send_request(req, 1'b0, none);
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        // some bursts run straight into the next one
        if ($urandom_range(0, 2) != 0)
          idle_gap($urandom_range(1, 8));
      end else begin
        burst_left--;
      end
    end

    idle_gap(1);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
